// ----- sv/qin_pkg.sv -----
// ----------------------------------------------------------------------------
// qin_pkg: shared types and helpers for the quadratic interpolated noise block
// Generator step, seed hash, draw scaling and state codes.
// ----------------------------------------------------------------------------
package qin_pkg;

  localparam int COUNT_BITS = 28;
  localparam int DSR_W      = 2 * COUNT_BITS + 1;  // widest divisor: L*(L+1)
  localparam int DND_W      = 65;                  // widest dividend: |rise| << 17
  localparam int CNT_W      = $clog2(DND_W + 1);
  localparam logic [31:0] MIN_FREQ = 32'd66;
  localparam logic [COUNT_BITS-1:0] LEN_MAX = {COUNT_BITS{1'b1}};

  localparam logic [0:0] CFG_SAMPLE_RATE = 1'b0;
  localparam logic [0:0] CFG_SEED        = 1'b1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SEED  = 11'b00000000010,
    S_DRAW1 = 11'b00000000100,
    S_DRAW2 = 11'b00000001000,
    S_START = 11'b00000010000,
    S_LEN   = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_DIVA  = 11'b00010000000,
    S_DIVB  = 11'b00100000000,
    S_TICK  = 11'b01000000000,
    S_LVL   = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } gen_t;

  function automatic gen_t taus_step(gen_t g);
    gen_t r;
    r.a = ((g.a & 32'hFFFFFFFE) << 12) ^ (((g.a << 13) ^ g.a) >> 19);
    r.b = ((g.b & 32'hFFFFFFF8) << 4)  ^ (((g.b << 2)  ^ g.b) >> 25);
    r.c = ((g.c & 32'hFFFFFFF0) << 17) ^ (((g.c << 3)  ^ g.c) >> 11);
    return r;
  endfunction

  function automatic gen_t seed_words(logic [30:0] seed);
    logic [31:0] h;
    gen_t r;
    h = {1'b0, seed};
    h = h + ~(h << 15);
    h = h ^ (h >> 10);
    h = h + (h << 3);
    h = h ^ (h >> 6);
    h = h + ~(h << 11);
    h = h ^ (h >> 16);
    r.a = 32'd1243598713 ^ h;
    if (r.a < 32'd2) r.a = 32'd1243598713;
    r.b = 32'd3093459404 ^ h;
    if (r.b < 32'd8) r.b = 32'd3093459404;
    r.c = 32'd1821928721 ^ h;
    if (r.c < 32'd16) r.c = 32'd1821928721;
    return r;
  endfunction

  // Q8.40 value in [-1,1) from the top 23 bits of the generator output
  function automatic logic signed [47:0] draw_value(gen_t g);
    logic [31:0] t;
    t = g.a ^ g.b ^ g.c;
    return $signed({7'b0, t[31:9], 18'b0}) - $signed(48'h0100_0000_0000);
  endfunction

  // sum of two levels halved, rounded toward zero
  function automatic logic signed [47:0] half_sum(logic signed [47:0] x,
                                                  logic signed [47:0] y);
    logic signed [48:0] s;
    s = {x[47], x} + {y[47], y};
    s = s + {48'b0, s[48]};
    return s[48:1];
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [48:0] v);
    if (v[48] != v[47]) return v[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    return v[47:0];
  endfunction

endpackage

// ----- sv/quadratic_interpolated_noise.sv -----
// ----------------------------------------------------------------------------
// quadratic_interpolated_noise: curved random noise from a three-word generator
// One word in per sample tick, one sample word out; a shared serial divider
// sets each segment's length and curvature.
// ----------------------------------------------------------------------------
//   channel  | handshake          | payload
//   freq     | freq_valid/stall   | frequency  u32 Q16.16
//   sample   | sample_valid/stall | sample     s24 Q1.23
//   cfg      | cfg_valid/ready    | cfg_index 2b, cfg_data 31b
//
// A tick inside a segment runs an accept, a rise and a level step. A tick
// that starts a segment adds 3 passes of the 65-step restoring divider plus
// setup. Reset and each seed write run a reseed, during which the block
// takes no word. A stalled sample holds the tick in its rise step.
// ----------------------------------------------------------------------------
module quadratic_interpolated_noise import qin_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                freq_valid,
  output logic                freq_stall,
  input  logic [31:0]         frequency,
  output logic                sample_valid,
  input  logic                sample_stall,
  output logic signed [23:0]  sample,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);

  state_t state;
  logic [17:0] sample_rate;
  logic [30:0] seed;
  gen_t        gen;
  logic signed [47:0] level, target_level, midpoint, rise;
  logic signed [63:0] bend, a_term;
  logic [COUNT_BITS-1:0] ticks_left, len;
  logic [31:0] freq_q;
  logic        d_neg;

  // serial divider
  logic [DSR_W-1:0] rem, dsr;
  logic [DND_W-1:0] dnd, quo;
  logic [CNT_W-1:0] cnt;
  logic [DSR_W:0]   trial;
  logic             ge;

  gen_t               gen_nx;
  logic signed [47:0] drawn;
  logic signed [48:0] diff;
  logic [48:0]        diff_mag;
  logic [47:0]        rise_mag;
  logic signed [47:0] bend_sh;
  logic signed [30:0] lvl_sh;
  logic signed [23:0] lvl_sat;
  logic [31:0]        f_clamp;
  logic [COUNT_BITS:0] len_p1;
  logic [DSR_W-1:0]   len_sq;
  logic               out_free;

  assign trial    = {rem, dnd[DND_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign gen_nx   = taus_step(gen);
  assign drawn    = draw_value(gen_nx);
  assign diff     = {midpoint[47], midpoint} - {level[47], level};
  assign diff_mag = diff[48] ? 49'(-diff) : 49'(diff);
  assign rise_mag = rise[47] ? 48'(-rise) : 48'(rise);
  assign bend_sh  = bend[63:16];
  assign lvl_sh   = level[47:17];
  assign f_clamp  = (freq_q < MIN_FREQ) ? MIN_FREQ : freq_q;
  assign len_p1   = {1'b0, len} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign len_sq   = {{(COUNT_BITS+1){1'b0}}, len} * {{COUNT_BITS{1'b0}}, len_p1};
  assign out_free = !sample_valid || !sample_stall;

  always_comb begin
    if (lvl_sh > 31'sd8388607) lvl_sat = 24'sh7FFFFF;
    else if (lvl_sh < -31'sd8388608) lvl_sat = 24'sh800000;
    else lvl_sat = lvl_sh[23:0];
  end

  assign freq_stall = rst || (state != S_IDLE) || cfg_valid;
  assign cfg_ready  = !rst && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SEED;
      sample_rate  <= 18'd48000;
      seed         <= 31'd1;
      sample_valid <= 1'b0;
      ticks_left   <= '0;
      cnt          <= '0;
    end else begin
      if (sample_valid && !sample_stall && state != S_TICK) sample_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == {1'b0, CFG_SAMPLE_RATE}) sample_rate <= cfg_data[17:0];
            else if (cfg_index == {1'b0, CFG_SEED}) begin
              seed  <= cfg_data;
              state <= S_SEED;
            end
          end else if (freq_valid) begin
            freq_q <= frequency;
            state  <= (ticks_left == '0) ? S_START : S_TICK;
          end
        end
        S_SEED: begin
          gen        <= seed_words(seed);
          rise       <= '0;
          bend       <= '0;
          ticks_left <= '0;
          state      <= S_DRAW1;
        end
        S_DRAW1: begin
          gen   <= gen_nx;
          level <= drawn;
          state <= S_DRAW2;
        end
        S_DRAW2: begin
          gen          <= gen_nx;
          target_level <= drawn;
          midpoint     <= half_sum(drawn, '0);
          state        <= S_IDLE;
        end
        S_START: begin
          gen          <= gen_nx;
          target_level <= drawn;
          level        <= midpoint;
          midpoint     <= half_sum(drawn, target_level);
          dnd          <= {{(DND_W-34){1'b0}}, sample_rate, 16'b0};
          dsr          <= {{(DSR_W-32){1'b0}}, f_clamp};
          rem          <= '0;
          cnt          <= CNT_W'(DND_W);
          state        <= S_LEN;
        end
        S_LEN, S_DIVA, S_DIVB: begin
          if (cnt != '0) begin
            // one restoring step: shift in a dividend bit, subtract if it fits
            rem <= ge ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
            quo <= {quo[DND_W-2:0], ge};
            dnd <= {dnd[DND_W-2:0], 1'b0};
            cnt <= cnt - CNT_W'(1);
          end else begin
            case (state)
              S_LEN: begin
                if (quo > DND_W'(LEN_MAX)) len <= LEN_MAX;
                else if (quo < DND_W'(2)) len <= COUNT_BITS'(2);
                else len <= quo[COUNT_BITS-1:0];
                state <= S_MUL;
              end
              S_DIVA: begin
                a_term <= d_neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
                dnd    <= {rise_mag, 17'b0};
                dsr    <= DSR_W'(len_p1);
                rem    <= '0;
                cnt    <= CNT_W'(DND_W);
                state  <= S_DIVB;
              end
              default: begin
                bend  <= a_term - (rise[47] ? -$signed(quo[63:0]) : $signed(quo[63:0]));
                state <= S_TICK;
              end
            endcase
          end
        end
        S_MUL: begin
          ticks_left <= len;
          dsr        <= len_sq;
          d_neg      <= diff[48];
          dnd        <= DND_W'({diff_mag, 17'b0});
          rem        <= '0;
          cnt        <= CNT_W'(DND_W);
          state      <= S_DIVA;
        end
        S_TICK: begin
          // hold until the sample register is free
          if (out_free) begin
            sample       <= lvl_sat;
            sample_valid <= 1'b1;
            rise         <= sat48({rise[47], rise} + {bend_sh[47], bend_sh});
            state        <= S_LVL;
          end
        end
        S_LVL: begin
          level      <= sat48({level[47], level} + {rise[47], rise});
          ticks_left <= ticks_left - COUNT_BITS'(1);
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/quadratic_interpolated_noise_tb.sv -----
// ----------------------------------------------------------------------------
// quadratic_interpolated_noise_tb: self-checking bench for the noise block
// Drives frequency words with random gaps and back-pressure, reprograms rate
// and seed between phases, and compares every sample word against a
// bit-exact fixed-point predictor of the curved noise.
// ----------------------------------------------------------------------------
module quadratic_interpolated_noise_tb import qin_pkg::*;;

  localparam logic [1:0] REG_RATE    = {1'b0, CFG_SAMPLE_RATE};
  localparam logic [1:0] REG_SEED    = {1'b0, CFG_SEED};
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam longint unsigned W32 = 64'hFFFF_FFFF;
  localparam longint SAT_HI = 64'sd140737488355327;
  localparam longint SAT_LO = -64'sd140737488355328;

  class noise_scoreboard;
    longint unsigned rate, seed_val, wa, wb, wc, ticks;
    longint lvl, tgt, mid, slope, curve;
    logic signed [23:0] expected_samples[$];
    int mismatches;

    function longint sat48(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function longint draw_level();
      longint unsigned t;
      wa = (((wa & 64'hFFFFFFFE) << 12) ^ ((((wa << 13) & W32) ^ wa) >> 19)) & W32;
      wb = (((wb & 64'hFFFFFFF8) << 4) ^ ((((wb << 2) & W32) ^ wb) >> 25)) & W32;
      wc = (((wc & 64'hFFFFFFF0) << 17) ^ ((((wc << 3) & W32) ^ wc) >> 11)) & W32;
      t = wa ^ wb ^ wc;
      return (longint'(t >> 9) - 64'sd4194304) * 64'sd262144;
    endfunction

    function void reseed();
      longint unsigned h;
      h = seed_val & W32;
      h = (h + (~(h << 15) & W32)) & W32;
      h ^= h >> 10;
      h = (h + (h << 3)) & W32;
      h ^= h >> 6;
      h = (h + (~(h << 11) & W32)) & W32;
      h ^= h >> 16;
      wa = 64'd1243598713 ^ h; if (wa < 2) wa = 64'd1243598713;
      wb = 64'd3093459404 ^ h; if (wb < 8) wb = 64'd3093459404;
      wc = 64'd1821928721 ^ h; if (wc < 16) wc = 64'd1821928721;
      lvl = draw_level();
      tgt = draw_level();
      mid = tgt / 2;
      slope = 0;
      curve = 0;
      ticks = 0;
    endfunction

    function void reset_state();
      rate = 48000;
      seed_val = 1;
      reseed();
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] data);
      if (idx == REG_RATE) rate = data & 64'h3FFFF;
      else if (idx == REG_SEED) begin
        seed_val = data;
        reseed();
      end
    endfunction

    function void open_segment(longint unsigned freq);
      longint prev, d, ta, tb;
      longint unsigned f, len, mag, q1, r1, den;
      prev = tgt;
      tgt = draw_level();
      lvl = mid;
      mid = (tgt + prev) / 2;
      f = (freq < 66) ? 66 : freq;
      len = (rate << 16) / f;
      if (len > ((64'd1 << COUNT_BITS) - 1)) len = (64'd1 << COUNT_BITS) - 1;
      if (len < 2) len = 2;
      ticks = len;
      d = mid - lvl;
      mag = longint'(d < 0 ? -d : d) << 17;
      ta = longint'(mag / (len * (len + 1)));
      if (d < 0) ta = -ta;
      den = len + 1;
      mag = (slope < 0) ? -slope : slope;
      q1 = mag / den;
      r1 = mag % den;
      tb = longint'((q1 << 17) + (r1 << 17) / den);
      if (slope < 0) tb = -tb;
      curve = ta - tb;
    endfunction

    function void predict_sample(logic [31:0] freq);
      longint s;
      if (ticks == 0) open_segment(freq);
      s = lvl >>> 17;
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      expected_samples.push_back(s[23:0]);
      slope = sat48(slope + (curve >>> 16));
      lvl = sat48(lvl + slope);
      ticks -= 1;
    endfunction

    function void check_sample(logic signed [23:0] got);
      logic signed [23:0] want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample word %0d", got);
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic freq_valid = 1'b0;
  logic freq_stall;
  logic [31:0] frequency = '0;
  logic sample_valid;
  logic sample_stall = 1'b0;
  logic signed [23:0] sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  noise_scoreboard sb = new();
  bit no_idle = 1'b0;
  int stall_left = 0;
  int long_hold = 0;
  logic [17:0] cur_rate = 18'd48000;

  quadratic_interpolated_noise u_dut (
    .clk(clk), .rst(rst),
    .freq_valid(freq_valid), .freq_stall(freq_stall), .frequency(frequency),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // check accepted words, then draw the next stall
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      sb.check_sample(sample);
      stall_left = no_idle ? 0 : $urandom_range(0, 6);
    end
  end

  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold--;
      sample_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      sample_stall <= 1'b1;
    end else begin
      sample_stall <= 1'b0;
    end
  end

  task automatic send_word(logic [31:0] f);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      freq_valid = 1'b0;
      frequency = $urandom;
      repeat (gap) @(negedge clk);
    end
    freq_valid = 1'b1;
    frequency = f;
    do @(posedge clk); while (freq_stall);
    sb.predict_sample(f);
    @(negedge clk);
  endtask

  // hold until every expected word is back, then let the tick finish
  task automatic drain();
    freq_valid = 1'b0;
    while (sb.expected_samples.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    if (idx == REG_RATE) cur_rate = data[17:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly short segments; now and then a raw word
  function automatic logic [31:0] pick_freq();
    longint unsigned f;
    int len;
    if (cur_rate == 0 || $urandom_range(0, 7) == 0) return $urandom;
    len = $urandom_range(2, 40);
    f = ((longint'(cur_rate) << 16) / len) + $urandom_range(0, 15);
    if (f > W32) f = W32;
    if (f < 66) f = 66 + $urandom_range(0, 3);
    return f[31:0];
  endfunction

  initial begin
    logic [17:0] rates[5];
    logic [31:0] directed[12];
    rates = '{18'd1, 18'd192000, 18'd44100, 18'd262143, 18'd48000};
    directed = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0001_0000 * 24000,
                 32'h0001_0000 * 16000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000 * 6000,
                 32'd67, 32'd66, 32'd65, 32'd0};
    repeat (10) @(negedge clk);
    rst = 1'b0;
    sb.reset_state();

    foreach (directed[i]) send_word(directed[i]);
    // long segment from the low clamp; restart via seed
    drain();
    write_reg(REG_RATE, 31'd0);
    write_reg(REG_SEED, 31'd0);
    repeat (4) send_word($urandom);
    send_word(32'd1);
    drain();
    write_reg(REG_SPARE_A, 31'($urandom));
    write_reg(REG_SPARE_B, 31'($urandom));
    write_reg(REG_RATE, 31'd192000);
    write_reg(REG_SEED, 31'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'd0);
    send_word(32'd0);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_RATE, (p == 4) ? 31'($urandom_range(1, 192000)) : 31'(rates[p]));
      write_reg(REG_SEED, 31'($urandom));
      for (int n = 0; n < 160; n++) begin
        if (p == 1 && n == 80) long_hold = 400;
        if (p == 2 && n == 80) drain();
        no_idle = (p == 3 && n < 60);
        send_word(pick_freq());
      end
      no_idle = 1'b0;
      drain();
    end

    repeat (300) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/qin_pkg.sv
sv/quadratic_interpolated_noise.sv
bench/quadratic_interpolated_noise_tb.sv
